// ===== hw/rtl/sfhb_pkg.sv =====
// Package for the sphere fill height bisection unit.
// Holds field widths, fixed-point constants, codes and state types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfhb_pkg;

    localparam int LENGTH_FRAC_BITS = 16;
    localparam int CUBE_SHIFT       = 2 * LENGTH_FRAC_BITS - 8;

    localparam int LEN_W   = 22;
    localparam int RAD_W   = 21;
    localparam int TOL_W   = 22;
    localparam int ITER_W  = 6;
    localparam int VOL_W   = 24;
    localparam int RES_W   = 28;
    localparam int CFG_W   = 22;
    localparam int IDX_W   = 2;

    localparam int H2_W    = 2 * LEN_W - LENGTH_FRAC_BITS;
    localparam int R3_W    = RAD_W + 2;
    localparam int MUL_A_W = H2_W;
    localparam int MUL_B_W = R3_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int CUBE_W  = H2_W + LEN_W - CUBE_SHIFT;
    localparam int QUAD_W  = H2_W + R3_W - CUBE_SHIFT;
    localparam int SUM_W   = RES_W + 1;

    localparam int VOL3_W  = VOL_W + 2;
    localparam int DIV_W   = 26;
    localparam int QUO_W   = 24;
    localparam logic [DIV_W-1:0] PI_Q24 = 26'd52707178;

    // The volume term is floor(3*V*2^VTERM_SH / PI_Q24). A reciprocal rounded up
    // with RECIP_SH >= VOL3_W fraction bits gives the quotient or one above it.
    localparam int VTERM_SH   = 24;
    localparam int RECIP_SH   = VOL3_W;
    localparam int RECIP_W    = 25;
    localparam int RCP_PROD_W = VOL3_W + RECIP_W;
    localparam int BACK_W     = QUO_W + DIV_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << (VTERM_SH + RECIP_SH)) + 64'(PI_Q24) - 64'd1) / 64'(PI_Q24));

    localparam logic signed [RES_W-1:0] RES_MAX = 28'sh7FFFFFF;
    localparam logic signed [RES_W-1:0] RES_MIN = 28'sh8000000;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 64;

    localparam logic [RAD_W-1:0]  RADIUS_RST  = 21'd65536;
    localparam logic [TOL_W-1:0]  TOL_RST     = 22'd66;
    localparam logic [ITER_W-1:0] MAX_ITER_RST = 6'd30;

    typedef enum logic [1:0] {
        ST_FOUND      = 2'd0,
        ST_NO_CONV    = 2'd1,
        ST_NO_BRACKET = 2'd2
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_RADIUS    = 2'd0,
        REG_TOLERANCE = 2'd1,
        REG_MAX_ITER  = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_E1,
        S_E2,
        S_E3,
        S_E4,
        S_CHECK,
        S_MID,
        S_STEP,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        EV_LO,
        EV_HI,
        EV_MID
    } eval_sel_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sphere_fill_height_bisection_unit.sv =====
// Top level of the sphere fill height bisection unit: sequencer, registers, ports.
// Depends on sfhb_pkg, sfhb_mul and sfhb_div.
//
// Finds the liquid height h in a spherical tank for a volume V by bisection
// on f(h) = h^3 - 3*r*h^2 + 3*V/pi, in fixed point.
// The input stream (s_tvalid, s_tready, s_tdata) carries one query per
// transaction: volume and two search bounds. The output stream (m_tvalid,
// m_tready, m_tdata) returns one result per query: status, height,
// iterations and residual. Radius, tolerance and iteration limit are set
// through the write port (cfg_wr_en, cfg_index, cfg_wdata); the user must
// write them only while idle, which the block itself does not enforce.
// A query is accepted in S_IDLE, waits in S_DIV for the volume term (reciprocal
// multiplication and one correction), evaluates both end points and makes the
// bracketing check; each bisection step then runs the midpoint, three products
// through the one shared multiplier, the residual and the update, and S_OUT
// loads the output register. One query is in work at a time.
// The finished result waits in the output register; a new query is taken
// as soon as the previous result is loaded, and a stalled receiver holds
// the sequencer only when a second result is ready.
// Reset restores the default radius (1.0 m), tolerance and limit (30)
// and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module sphere_fill_height_bisection_unit
    import sfhb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // volume[23:0], lower_bound[45:24], upper_bound[67:46], zero fill above
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // status[1:0], height[23:2], iterations[29:24], residual[57:30], zero fill above
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    state_t    state_reg, state_next;
    eval_sel_t sel_reg, sel_next;

    logic [RAD_W-1:0]  radius_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] max_iter_reg;

    logic [LEN_W-1:0]  x1_reg, x1_next, x2_reg, x2_next, x3_reg, x3_next;
    logic [R3_W-1:0]   r3_reg, r3_next;
    logic [QUO_W-1:0]  cst_reg, cst_next;
    logic [H2_W-1:0]   h2_reg, h2_next;
    logic [CUBE_W-1:0] cube_reg, cube_next;
    logic signed [RES_W-1:0] f1_reg, f1_next, f3_reg, f3_next, f2_reg, f2_next;
    logic [ITER_W-1:0] it_reg, it_next;

    status_t           res_status_reg, res_status_next;
    logic [LEN_W-1:0]  res_height_reg, res_height_next;
    logic [ITER_W-1:0] res_iter_reg, res_iter_next;
    logic signed [RES_W-1:0] res_resid_reg, res_resid_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quot;

    logic [LEN_W-1:0]  h;
    logic [LEN_W-1:0]  in_lo, in_hi;
    logic [QUAD_W-1:0] quad;
    logic signed [SUM_W-1:0] f_sum;
    logic signed [RES_W-1:0] f_sat;
    logic [LEN_W:0]    mid_sum;
    logic [LEN_W-1:0]  w;
    logic              same_sign, opp_sign;

    sfhb_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    sfhb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .vol      (s_tdata[VOL_W-1:0]),
        .done_reg (div_done),
        .quot_reg (div_quot)
    );

    assign in_lo = s_tdata[45:24];
    assign in_hi = s_tdata[67:46];

    always_comb
    begin
        case (sel_reg)
            EV_LO:   h = x1_reg;
            EV_HI:   h = x3_reg;
            EV_MID:  h = x2_reg;
            default: h = x2_reg;
        endcase
    end

    assign quad  = prod[CUBE_SHIFT+QUAD_W-1:CUBE_SHIFT];
    assign f_sum = $signed({3'b000, cube_reg}) - $signed({2'b00, quad})
                 + $signed({5'b00000, cst_reg});
    always_comb
    begin
        if (f_sum > $signed({RES_MAX[RES_W-1], RES_MAX}))
            f_sat = RES_MAX;
        else if (f_sum < $signed({RES_MIN[RES_W-1], RES_MIN}))
            f_sat = RES_MIN;
        else
            f_sat = f_sum[RES_W-1:0];
    end

    assign mid_sum   = {1'b0, x1_reg} + {1'b0, x3_reg};
    assign same_sign = (f1_reg != '0) && (f3_reg != '0)
                     && (f1_reg[RES_W-1] == f3_reg[RES_W-1]);
    assign opp_sign  = (f1_reg != '0) && (f2_reg != '0)
                     && (f1_reg[RES_W-1] != f2_reg[RES_W-1]);
    assign w = opp_sign ? LEN_W'((x2_reg - x1_reg) >> 1) : LEN_W'((x3_reg - x2_reg) >> 1);

    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        x1_next         = x1_reg;
        x2_next         = x2_reg;
        x3_next         = x3_reg;
        r3_next         = r3_reg;
        cst_next        = cst_reg;
        h2_next         = h2_reg;
        cube_next       = cube_reg;
        f1_next         = f1_reg;
        f2_next         = f2_reg;
        f3_next         = f3_reg;
        it_next         = it_reg;
        res_status_next = res_status_reg;
        res_height_next = res_height_reg;
        res_iter_next   = res_iter_reg;
        res_resid_next  = res_resid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        div_start       = 1'b0;
        mul_a           = {{(MUL_A_W-LEN_W){1'b0}}, h};
        mul_b           = {{(MUL_B_W-LEN_W){1'b0}}, h};

        case (state_reg)
            S_IDLE:
            begin
                div_start = s_tvalid;
                if (s_tvalid)
                begin
                    x1_next    = (in_lo > in_hi) ? in_hi : in_lo;
                    x3_next    = (in_lo > in_hi) ? in_lo : in_hi;
                    r3_next    = {2'b00, radius_reg} + {1'b0, radius_reg, 1'b0};
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cst_next   = div_quot;
                    sel_next   = EV_LO;
                    state_next = S_E1;
                end
            end
            S_E1:
            begin
                state_next = S_E2;
            end
            S_E2:
            begin
                mul_a      = prod[LENGTH_FRAC_BITS+H2_W-1:LENGTH_FRAC_BITS];
                h2_next    = prod[LENGTH_FRAC_BITS+H2_W-1:LENGTH_FRAC_BITS];
                state_next = S_E3;
            end
            S_E3:
            begin
                mul_a      = h2_reg;
                mul_b      = r3_reg;
                cube_next  = prod[CUBE_SHIFT+CUBE_W-1:CUBE_SHIFT];
                state_next = S_E4;
            end
            S_E4:
            begin
                case (sel_reg)
                    EV_LO:
                    begin
                        f1_next    = f_sat;
                        sel_next   = EV_HI;
                        state_next = S_E1;
                    end
                    EV_HI:
                    begin
                        f3_next    = f_sat;
                        state_next = S_CHECK;
                    end
                    default:
                    begin
                        f2_next    = f_sat;
                        state_next = S_STEP;
                    end
                endcase
            end
            S_CHECK:
            begin
                it_next = '0;
                if (same_sign)
                begin
                    res_status_next = ST_NO_BRACKET;
                    res_height_next = '0;
                    res_iter_next   = '0;
                    res_resid_next  = '0;
                    state_next      = S_OUT;
                end
                else if (max_iter_reg == '0)
                begin
                    res_status_next = ST_NO_CONV;
                    res_height_next = '0;
                    res_iter_next   = '0;
                    res_resid_next  = '0;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                x2_next    = mid_sum[LEN_W:1];
                sel_next   = EV_MID;
                state_next = S_E1;
            end
            S_STEP:
            begin
                if (opp_sign)
                begin
                    x3_next = x2_reg;
                end
                else
                begin
                    x1_next = x2_reg;
                    f1_next = f2_reg;
                end
                res_height_next = x2_reg;
                res_resid_next  = f2_reg;
                if (w < tol_reg)
                begin
                    res_status_next = ST_FOUND;
                    res_iter_next   = it_reg;
                    state_next      = S_OUT;
                end
                else if (it_reg + 1'b1 == max_iter_reg)
                begin
                    res_status_next = ST_NO_CONV;
                    res_iter_next   = max_iter_reg;
                    state_next      = S_OUT;
                end
                else
                begin
                    it_next    = it_reg + 1'b1;
                    state_next = S_MID;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, res_resid_reg, res_iter_reg, res_height_reg,
                                     res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sel_reg      <= EV_LO;
            m_tvalid_reg <= 1'b0;
            radius_reg   <= RADIUS_RST;
            tol_reg      <= TOL_RST;
            max_iter_reg <= MAX_ITER_RST;
        end
        else
        begin
            state_reg    <= state_next;
            sel_reg      <= sel_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_RADIUS:    radius_reg   <= cfg_wdata[RAD_W-1:0];
                    REG_TOLERANCE: tol_reg      <= cfg_wdata[TOL_W-1:0];
                    REG_MAX_ITER:  max_iter_reg <= cfg_wdata[ITER_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg         <= x1_next;
        x2_reg         <= x2_next;
        x3_reg         <= x3_next;
        r3_reg         <= r3_next;
        cst_reg        <= cst_next;
        h2_reg         <= h2_next;
        cube_reg       <= cube_next;
        f1_reg         <= f1_next;
        f2_reg         <= f2_next;
        f3_reg         <= f3_next;
        it_reg         <= it_next;
        res_status_reg <= res_status_next;
        res_height_reg <= res_height_next;
        res_iter_reg   <= res_iter_next;
        res_resid_reg  <= res_resid_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfhb_mul.sv =====
// Shared registered multiplier used for every product of the cubic.
// Depends on sfhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfhb_mul
    import sfhb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic      [PROD_W-1:0]  prod_reg
);

    logic [PROD_W-1:0] prod_next;

    assign prod_next = {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfhb_div.sv =====
// Volume term floor(3*V*2^24 / PI_Q24) by reciprocal multiplication and one
// compare and correct step through registers x, prod, back and quot. Depends on sfhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfhb_div
    import sfhb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [VOL_W-1:0] vol,
    output logic                  done_reg,
    output logic      [QUO_W-1:0] quot_reg
);

    logic [VOL3_W-1:0]     x_reg, x_next;
    logic [RCP_PROD_W-1:0] prod_reg, prod_next;
    logic [BACK_W-1:0]     back_reg, back_next;
    logic [QUO_W-1:0]      quot_next;
    logic [2:0]            pipe_reg, pipe_next;
    logic                  done_next;
    logic [VOL3_W-1:0]     vol3;
    logic [QUO_W-1:0]      q0;

    assign vol3      = {2'b00, vol} + {1'b0, vol, 1'b0};
    assign x_next    = start ? vol3 : x_reg;
    assign prod_next = {{RECIP_W{1'b0}}, x_reg} * {{VOL3_W{1'b0}}, RECIP};
    assign q0        = prod_reg[RECIP_SH+QUO_W-1:RECIP_SH];
    assign back_next = {{DIV_W{1'b0}}, q0} * {{QUO_W{1'b0}}, PI_Q24};

    // The estimate is one too high exactly when it times pi overshoots the dividend.
    assign quot_next = (back_reg > {x_reg, {VTERM_SH{1'b0}}}) ? q0 - 1'b1 : q0;
    assign pipe_next = {pipe_reg[1:0], start};
    assign done_next = pipe_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pipe_reg <= pipe_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        back_reg <= back_next;
        quot_reg <= quot_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfhb_checker.sv =====
// Port-level checker for the sphere fill height bisection unit, bound to the top.
// Depends on sfhb_pkg and sphere_fill_height_bisection_unit.
`timescale 1ns / 1ps
`default_nettype none

module sfhb_checker
    import sfhb_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction changed while stalled");

    // Once a query is taken the unit is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted transaction");

    // No result can appear the cycle after a query is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared without computation time");

    // A rejected interval reports all other fields as zero.
    a_no_bracket_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_NO_BRACKET |-> m_tdata[57:2] == '0)
        else $error("non-bracketing result carries nonzero fields");

endmodule

bind sphere_fill_height_bisection_unit sfhb_checker u_sfhb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
